/* design/mie_pkg.sv */
// Shared types for the modular inverse unit.
// No dependencies.
package mie_pkg;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_ALIGN = 6'b000100,
		S_SUB   = 6'b001000,
		S_FIX   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	localparam logic [63:0] MODULUS_RESET = 64'd998244353;
	localparam logic [0:0]  REG_MODULUS   = 1'b0;

endpackage

/* design/mie_core.sv */
// Extended Euclid datapath: shift-subtract division, one quotient bit per cycle.
// Depends on mie_pkg.
module mie_core #(
	parameter int WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  ack,
	input  logic [WIDTH-1:0]      a,
	input  logic [WIDTH-1:0]      m,
	output mie_pkg::core_stat_t   stat,
	output logic [WIDTH-1:0]      inv,
	output logic                  ok
);
	import mie_pkg::*;

	localparam int KW = $clog2(WIDTH + 1);

	state_t                    state_q;
	logic [WIDTH:0]            r0_q, r1_q, d_q;
	logic signed [WIDTH+1:0]   t0_q, t1_q, tt_q;
	logic [KW-1:0]             k_q;
	logic [WIDTH-1:0]          m_q;
	logic [WIDTH-1:0]          inv_q;
	logic                      ok_q;

	logic                      ge;
	logic [WIDTH:0]            r0_n;
	logic signed [WIDTH+1:0]   t0_n;
	logic signed [WIDTH+1:0]   t0_fix;
	logic signed [WIDTH+1:0]   m_s;

	assign m_s    = $signed({2'b00, m_q});
	assign ge     = (r0_q >= d_q);
	assign r0_n   = ge ? (r0_q - d_q) : r0_q;
	assign t0_n   = ge ? (t0_q - tt_q) : t0_q;
	assign t0_fix = t0_q[WIDTH+1] ? (t0_q + m_s) : t0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_CHECK;
				S_CHECK: state_q <= (r1_q == '0) ? S_FIX : S_ALIGN;
				S_ALIGN: if ({1'b0, r0_q} < {d_q, 1'b0}) state_q <= S_SUB;
				S_SUB: if (k_q == '0) state_q <= S_CHECK;
				S_FIX: state_q <= S_DONE;
				S_DONE: if (ack) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				m_q  <= m;
				r0_q <= {1'b0, m};
				r1_q <= (m == '0) ? '0 : {1'b0, a};
				t0_q <= '0;
				t1_q <= (WIDTH+2)'(1);
			end
			S_CHECK: begin
				d_q  <= r1_q;
				tt_q <= t1_q;
				k_q  <= '0;
			end
			S_ALIGN: begin
				if ({1'b0, r0_q} >= {d_q, 1'b0}) begin
					d_q  <= {d_q[WIDTH-1:0], 1'b0};
					tt_q <= tt_q <<< 1;
					k_q  <= k_q + 1'b1;
				end
			end
			S_SUB: begin
				if (k_q == '0) begin
					r0_q <= r1_q;
					r1_q <= r0_n;
					t0_q <= t1_q;
					t1_q <= t0_n;
				end else begin
					r0_q <= r0_n;
					t0_q <= t0_n;
					d_q  <= d_q >> 1;
					tt_q <= tt_q >>> 1;
					k_q  <= k_q - 1'b1;
				end
			end
			S_FIX: begin
				ok_q  <= (r0_q == (WIDTH+1)'(1));
				if (r0_q != (WIDTH+1)'(1))
					inv_q <= '0;
				else if (t0_fix >= m_s)
					inv_q <= WIDTH'(t0_fix - m_s);
				else
					inv_q <= t0_fix[WIDTH-1:0];
			end
			S_DONE: ;
			default: ;
		endcase
	end

	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign inv = inv_q;
	assign ok  = ok_q;

endmodule

/* design/modular_inverse_euclid_unit.sv */
// Modular inverse unit top level: APB register, word handshakes, Euclid core.
// Depends on mie_pkg and mie_core.
// One word at a time: each value is answered with its inverse modulo the
// programmed modulus (reset 998244353) and a has_inverse flag (gcd == 1).
// Values need no prior reduction. Each step of the Euclid core is a check,
// an alignment of the divisor one quotient bit at a time and a subtraction
// one quotient bit at a time; a fix state and a done state finish the word.
// in_stall is high from acceptance until the result word is taken.
// Program the modulus only while idle.
module modular_inverse_euclid_unit #(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [((WIDTH > 32) ? 64 : 32)-1:0] pwdata,
	output logic [((WIDTH > 32) ? 64 : 32)-1:0] prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [WIDTH-1:0]    value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [WIDTH-1:0]    inverse,
	output logic                has_inverse
);
	import mie_pkg::*;

	localparam int DW = (WIDTH > 32) ? 64 : 32;

	logic [WIDTH-1:0] modulus_q;
	core_stat_t       stat;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_MODULUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= WIDTH'(MODULUS_RESET);
		end else if (wr_en) begin
			modulus_q <= pwdata[WIDTH-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_MODULUS) ? DW'(modulus_q) : '0;

	mie_core #(.WIDTH(WIDTH)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_valid && !stat.busy),
		.ack    (!out_stall),
		.a      (value),
		.m      (modulus_q),
		.stat   (stat),
		.inv    (inverse),
		.ok     (has_inverse)
	);

	assign in_stall  = stat.busy;
	assign out_valid = stat.done;

endmodule

/* design/mie_checker.sv */
// Port-level checks for the modular inverse unit, bound to the top level.
// No dependencies.
module mie_checker #(
	parameter int WIDTH = 32
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [WIDTH-1:0] inverse,
	input logic             has_inverse
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(inverse) && $stable(has_inverse))
		else $error("result word changed while stalled");

	a_no_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_inverse |-> inverse == '0)
		else $error("inverse nonzero without has_inverse");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("unit not busy after accepting a word");

endmodule

bind modular_inverse_euclid_unit mie_checker #(.WIDTH(WIDTH)) u_mie_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.inverse     (inverse),
	.has_inverse (has_inverse)
);
